// ----- design/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

   // default heap size in bytes and allocation granule
   localparam int HEAP_BYTES_DEF = 65536;
   localparam int GRAIN          = 16;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_REALLOC = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NULL    = 2'd1,
      ST_NOSPACE = 2'd2,
      ST_BADPTR  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_PTR_CHECK,
      S_WALK_READ,
      S_WALK_CHECK,
      S_UNLINK,
      S_SPLIT,
      S_MARK,
      S_GROW,
      S_ALLOC_DONE,
      S_RELEASE,
      S_RESP_OLD,
      S_RESP_CUR
   } state_type;

   // header store write kinds
   typedef enum logic [2:0] {
      W_NONE,
      W_CLEAR,
      W_UNLINK,
      W_SPLIT,
      W_MARK,
      W_GROW,
      W_RELEASE
   } wr_op_type;

   // which block a response reports
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_OLD,
      SRC_CUR
   } src_type;

   typedef struct packed {
      logic       latch;
      logic       walk_init;
      logic       walk_adv;
      logic       take_cur;
      logic       save_old;
      logic       rd_ptr;
      logic       rd_cur;
      logic       count_alloc;
      wr_op_type  wr_op;
      logic       respond;
      status_type rsp_code;
      src_type    rsp_src;
      logic       rsp_ptr;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       present;
      logic       size_zero;
      logic       ptr_bad;
      logic       hdr_bad;
      logic       fits;
      logic       walk_go;
      logic       grow_ok;
      logic       clear_done;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/ffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate, free and reallocate requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ffa_pkg::stat_type stat,
   output ffa_pkg::cmd_type      cmd
);

   ffa_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffa_pkg::S_CLEAR: begin
            if (stat.clear_done) state_in = ffa_pkg::S_IDLE;
         end
         ffa_pkg::S_IDLE: begin
            if (start) state_in = ffa_pkg::S_DISPATCH;
         end
         ffa_pkg::S_DISPATCH: begin
            state_in = ffa_pkg::S_IDLE;
            case (stat.action)
               ffa_pkg::ACT_ALLOC: begin
                  if (!stat.size_zero) state_in = ffa_pkg::S_WALK_READ;
               end
               ffa_pkg::ACT_FREE: begin
                  if (stat.present && !stat.ptr_bad) state_in = ffa_pkg::S_PTR_CHECK;
               end
               ffa_pkg::ACT_REALLOC: begin
                  if (!stat.present) begin
                     if (!stat.size_zero) state_in = ffa_pkg::S_WALK_READ;
                  end else if (!stat.size_zero && !stat.ptr_bad) begin
                     state_in = ffa_pkg::S_PTR_CHECK;
                  end
               end
               default: state_in = ffa_pkg::S_IDLE;
            endcase
         end
         ffa_pkg::S_PTR_CHECK: begin
            if (stat.hdr_bad) state_in = ffa_pkg::S_IDLE;
            else if (stat.action == ffa_pkg::ACT_FREE) state_in = ffa_pkg::S_RELEASE;
            else if (stat.fits) state_in = ffa_pkg::S_RESP_OLD;
            else state_in = ffa_pkg::S_WALK_READ;
         end
         ffa_pkg::S_WALK_READ: begin
            state_in = stat.walk_go ? ffa_pkg::S_WALK_CHECK : ffa_pkg::S_GROW;
         end
         ffa_pkg::S_WALK_CHECK: begin
            state_in = stat.fits ? ffa_pkg::S_UNLINK : ffa_pkg::S_WALK_READ;
         end
         ffa_pkg::S_UNLINK:  state_in = ffa_pkg::S_SPLIT;
         ffa_pkg::S_SPLIT:   state_in = ffa_pkg::S_MARK;
         ffa_pkg::S_MARK:    state_in = ffa_pkg::S_ALLOC_DONE;
         ffa_pkg::S_GROW: begin
            state_in = stat.grow_ok ? ffa_pkg::S_ALLOC_DONE : ffa_pkg::S_IDLE;
         end
         ffa_pkg::S_ALLOC_DONE: begin
            if (stat.action == ffa_pkg::ACT_REALLOC && stat.present)
               state_in = ffa_pkg::S_RELEASE;
            else
               state_in = ffa_pkg::S_RESP_CUR;
         end
         ffa_pkg::S_RELEASE: begin
            state_in = (stat.action == ffa_pkg::ACT_FREE) ? ffa_pkg::S_RESP_OLD
                                                          : ffa_pkg::S_RESP_CUR;
         end
         ffa_pkg::S_RESP_OLD: state_in = ffa_pkg::S_IDLE;
         ffa_pkg::S_RESP_CUR: state_in = ffa_pkg::S_IDLE;
         default:             state_in = ffa_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd          = '0;
      cmd.wr_op    = ffa_pkg::W_NONE;
      cmd.rsp_code = ffa_pkg::ST_OK;
      cmd.rsp_src  = ffa_pkg::SRC_NONE;
      busy         = (state_ff != ffa_pkg::S_IDLE);
      case (state_ff)
         ffa_pkg::S_CLEAR: cmd.wr_op = ffa_pkg::W_CLEAR;
         ffa_pkg::S_IDLE:  cmd.latch = start;
         ffa_pkg::S_DISPATCH: begin
            case (stat.action)
               ffa_pkg::ACT_ALLOC: begin
                  if (stat.size_zero) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = ffa_pkg::ST_NULL;
                  end else begin
                     cmd.walk_init = 1'b1;
                  end
               end
               ffa_pkg::ACT_FREE: begin
                  if (!stat.present) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = ffa_pkg::ST_NULL;
                  end else if (stat.ptr_bad) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = ffa_pkg::ST_BADPTR;
                  end else begin
                     cmd.rd_ptr = 1'b1;
                  end
               end
               ffa_pkg::ACT_REALLOC: begin
                  if (stat.size_zero) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = ffa_pkg::ST_NULL;
                  end else if (!stat.present) begin
                     cmd.walk_init = 1'b1;
                  end else if (stat.ptr_bad) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = ffa_pkg::ST_BADPTR;
                  end else begin
                     cmd.rd_ptr = 1'b1;
                  end
               end
               default: begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_code = ffa_pkg::ST_NULL;
               end
            endcase
         end
         ffa_pkg::S_PTR_CHECK: begin
            cmd.save_old = 1'b1;
            if (stat.hdr_bad) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = ffa_pkg::ST_BADPTR;
            end else if (stat.action != ffa_pkg::ACT_FREE && !stat.fits) begin
               cmd.walk_init = 1'b1;
            end
         end
         ffa_pkg::S_WALK_READ:  cmd.rd_cur = stat.walk_go;
         ffa_pkg::S_WALK_CHECK: begin
            cmd.take_cur = stat.fits;
            cmd.walk_adv = !stat.fits;
         end
         ffa_pkg::S_UNLINK: cmd.wr_op = ffa_pkg::W_UNLINK;
         ffa_pkg::S_SPLIT:  cmd.wr_op = ffa_pkg::W_SPLIT;
         ffa_pkg::S_MARK:   cmd.wr_op = ffa_pkg::W_MARK;
         ffa_pkg::S_GROW: begin
            if (stat.grow_ok) begin
               cmd.wr_op = ffa_pkg::W_GROW;
            end else begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = ffa_pkg::ST_NOSPACE;
            end
         end
         ffa_pkg::S_ALLOC_DONE: cmd.count_alloc = 1'b1;
         ffa_pkg::S_RELEASE:    cmd.wr_op = ffa_pkg::W_RELEASE;
         ffa_pkg::S_RESP_OLD: begin
            cmd.respond = 1'b1;
            cmd.rsp_src = ffa_pkg::SRC_OLD;
            cmd.rsp_ptr = (stat.action != ffa_pkg::ACT_FREE);
         end
         ffa_pkg::S_RESP_CUR: begin
            cmd.respond = 1'b1;
            cmd.rsp_src = ffa_pkg::SRC_CUR;
            cmd.rsp_ptr = 1'b1;
         end
         default: cmd.latch = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/ffa_datapath.sv -----
// ----------------------------------------------------------------------------
// ffa_datapath
// Header store, free list head, heap top, statistics and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_datapath #(
   parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ffa_pkg::cmd_type  cmd,
   output ffa_pkg::stat_type      stat,
   input  wire logic [1:0]        req_action,
   input  wire logic [16:0]       req_size_bytes,
   input  wire logic [15:0]       req_pointer_offset,
   input  wire logic              req_pointer_present,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic                   rsp_result_present,
   output logic [15:0]            rsp_result_offset,
   output logic [16:0]            rsp_granted_bytes,
   output logic [16:0]            rsp_bytes_in_use,
   output logic [16:0]            rsp_peak_bytes,
   output logic [31:0]            rsp_alloc_total,
   output logic [31:0]            rsp_free_total
);

   localparam int GRANULES = HEAP_BYTES / ffa_pkg::GRAIN;
   localparam int GW       = $clog2(GRANULES);
   localparam int SW       = $clog2(HEAP_BYTES);
   localparam int TW       = $clog2(HEAP_BYTES + 1);
   localparam int AW       = ((TW > 18) ? TW : 18) + 1;
   localparam int STW      = $clog2(GRANULES + 1);

   typedef struct packed {
      logic          hdr;
      logic          is_free;
      logic          link_ok;
      logic [SW-1:0] size;
      logic [GW-1:0] link;
   } entry_type;

   entry_type mem [0:GRANULES-1];
   entry_type rdata_ff;

   // request registers
   logic [1:0]   action_ff;
   logic [16:0]  size_ff;
   logic [15:0]  ptr_ff;
   logic         present_ff;

   // allocator state
   logic [GW-1:0]  head_ff;
   logic           head_ok_ff;
   logic [TW-1:0]  top_ff;
   logic [TW-1:0]  used_ff;
   logic [TW-1:0]  peak_ff;
   logic [31:0]    alloc_cnt_ff;
   logic [31:0]    free_cnt_ff;
   logic [GW-1:0]  clr_ff;

   // walk and operation registers
   logic [GW-1:0]  cur_ff;
   logic           cur_ok_ff;
   logic [GW-1:0]  prev_ff;
   logic           prev_ok_ff;
   logic [STW-1:0] steps_ff;
   entry_type      prev_ent_ff;
   entry_type      cur_ent_ff;
   logic [SW-1:0]  cur_size_ff;
   logic [GW-1:0]  old_ff;
   entry_type      old_ent_ff;

   // derived values
   logic [AW-1:0] rnd_w, off_w, h_w, r_w, need_w, res_off_w;
   logic [AW-1:0] grant_w, used_w, peak_w;
   logic [GW-1:0] ptr_idx, r_idx, top_idx, rd_addr, wa, res_g;
   logic [TW-1:0] used_add;
   logic          split_go, r_ok, we;
   entry_type     wd;

   // size rounding and pointer decode
   always_comb begin
      rnd_w   = (AW'(size_ff) + AW'(15)) & ~AW'(15);
      off_w   = AW'(ptr_ff);
      h_w     = off_w - AW'(ffa_pkg::GRAIN);
      ptr_idx = GW'(h_w >> 4);
      r_w     = AW'(cur_ff) + AW'(1) + (rnd_w >> 4);
      r_idx   = GW'(r_w);
      r_ok    = r_w < AW'(GRANULES);
      need_w  = rnd_w + AW'(ffa_pkg::GRAIN);
      top_idx = GW'(AW'(top_ff) >> 4);
      split_go = AW'(cur_ent_ff.size) >= rnd_w + AW'(2 * ffa_pkg::GRAIN);
      used_add = used_ff + TW'(cur_size_ff);
   end

   // status to the controller
   always_comb begin
      stat.action     = ffa_pkg::action_type'(action_ff);
      stat.present    = present_ff;
      stat.size_zero  = (size_ff == 17'd0);
      stat.ptr_bad    = (off_w < AW'(ffa_pkg::GRAIN)) || (ptr_ff[3:0] != 4'd0) ||
                        (h_w >= AW'(top_ff));
      stat.hdr_bad    = !rdata_ff.hdr || rdata_ff.is_free;
      stat.fits       = AW'(rdata_ff.size) >= rnd_w;
      stat.walk_go    = cur_ok_ff && (AW'(steps_ff) < AW'(GRANULES)) &&
                        (AW'(cur_ff) < AW'(GRANULES));
      stat.grow_ok    = (AW'(top_ff) + need_w <= AW'(HEAP_BYTES)) &&
                        (AW'(top_idx) < AW'(GRANULES));
      stat.clear_done = (AW'(clr_ff) == AW'(GRANULES - 1));
   end

   // header store write selection
   always_comb begin
      we = 1'b0;
      wa = cur_ff;
      wd = '0;
      case (cmd.wr_op)
         ffa_pkg::W_CLEAR: begin
            we = 1'b1;
            wa = clr_ff;
         end
         ffa_pkg::W_UNLINK: begin
            we         = prev_ok_ff;
            wa         = prev_ff;
            wd         = prev_ent_ff;
            wd.link_ok = cur_ent_ff.link_ok;
            wd.link    = cur_ent_ff.link;
         end
         ffa_pkg::W_SPLIT: begin
            we = split_go && r_ok;
            wa = r_idx;
            wd = '{hdr: 1'b1, is_free: 1'b1, link_ok: head_ok_ff,
                   size: SW'(AW'(cur_ent_ff.size) - rnd_w - AW'(ffa_pkg::GRAIN)),
                   link: head_ff};
         end
         ffa_pkg::W_MARK: begin
            we = 1'b1;
            wd = '{hdr: cur_ent_ff.hdr, is_free: 1'b0, link_ok: 1'b0,
                   size: cur_size_ff, link: '0};
         end
         ffa_pkg::W_GROW: begin
            we = 1'b1;
            wa = top_idx;
            wd = '{hdr: 1'b1, is_free: 1'b0, link_ok: 1'b0, size: SW'(rnd_w), link: '0};
         end
         ffa_pkg::W_RELEASE: begin
            we = 1'b1;
            wa = old_ff;
            wd = '{hdr: old_ent_ff.hdr, is_free: 1'b1, link_ok: head_ok_ff,
                   size: old_ent_ff.size, link: head_ff};
         end
         default: we = 1'b0;
      endcase
   end

   assign rd_addr = cmd.rd_ptr ? ptr_idx : cur_ff;

   // header store
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (cmd.rd_ptr || cmd.rd_cur) rdata_ff <= mem[rd_addr];
   end

   // request capture and walk registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff  <= req_action;
         size_ff    <= req_size_bytes;
         ptr_ff     <= req_pointer_offset;
         present_ff <= req_pointer_present;
      end
      if (cmd.walk_init) begin
         cur_ff     <= head_ff;
         cur_ok_ff  <= head_ok_ff;
         prev_ok_ff <= 1'b0;
         steps_ff   <= '0;
      end
      if (cmd.walk_adv) begin
         prev_ff     <= cur_ff;
         prev_ok_ff  <= 1'b1;
         prev_ent_ff <= rdata_ff;
         cur_ff      <= rdata_ff.link;
         cur_ok_ff   <= rdata_ff.link_ok;
         steps_ff    <= steps_ff + STW'(1);
      end
      if (cmd.take_cur) cur_ent_ff <= rdata_ff;
      if (cmd.save_old) begin
         old_ff     <= ptr_idx;
         old_ent_ff <= rdata_ff;
      end
      if (cmd.wr_op == ffa_pkg::W_SPLIT)
         cur_size_ff <= split_go ? SW'(rnd_w) : cur_ent_ff.size;
      if (cmd.wr_op == ffa_pkg::W_GROW) begin
         cur_ff      <= top_idx;
         cur_size_ff <= SW'(rnd_w);
      end
   end

   // free list head, heap top and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         head_ok_ff   <= 1'b0;
         top_ff       <= '0;
         used_ff      <= '0;
         peak_ff      <= '0;
         alloc_cnt_ff <= '0;
         free_cnt_ff  <= '0;
         clr_ff       <= '0;
      end else begin
         case (cmd.wr_op)
            ffa_pkg::W_CLEAR: clr_ff <= clr_ff + GW'(1);
            ffa_pkg::W_UNLINK: begin
               if (!prev_ok_ff) begin
                  head_ff    <= cur_ent_ff.link;
                  head_ok_ff <= cur_ent_ff.link_ok;
               end
            end
            ffa_pkg::W_SPLIT: begin
               if (split_go && r_ok) begin
                  head_ff    <= r_idx;
                  head_ok_ff <= 1'b1;
               end
            end
            ffa_pkg::W_GROW: top_ff <= TW'(AW'(top_ff) + need_w);
            ffa_pkg::W_RELEASE: begin
               head_ff     <= old_ff;
               head_ok_ff  <= 1'b1;
               used_ff     <= used_ff - TW'(old_ent_ff.size);
               free_cnt_ff <= free_cnt_ff + 32'd1;
            end
            default: clr_ff <= clr_ff;
         endcase
         if (cmd.count_alloc) begin
            used_ff      <= used_add;
            alloc_cnt_ff <= alloc_cnt_ff + 32'd1;
            if (used_add > peak_ff) peak_ff <= used_add;
         end
      end
   end

   // result selection
   always_comb begin
      res_g   = (cmd.rsp_src == ffa_pkg::SRC_OLD) ? old_ff : cur_ff;
      case (cmd.rsp_src)
         ffa_pkg::SRC_OLD: grant_w = AW'(old_ent_ff.size);
         ffa_pkg::SRC_CUR: grant_w = AW'(cur_size_ff);
         default:          grant_w = '0;
      endcase
      res_off_w = cmd.rsp_ptr ? ((AW'(res_g) << 4) + AW'(ffa_pkg::GRAIN)) : '0;
      used_w    = AW'(used_ff);
      peak_w    = AW'(peak_ff);
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_status         <= cmd.rsp_code;
         rsp_result_present <= cmd.rsp_ptr;
         rsp_result_offset  <= res_off_w[15:0];
         rsp_granted_bytes  <= grant_w[16:0];
      end
   end

   assign rsp_bytes_in_use = used_w[16:0];
   assign rsp_peak_bytes   = peak_w[16:0];
   assign rsp_alloc_total  = alloc_cnt_ff;
   assign rsp_free_total   = free_cnt_ff;

endmodule

`default_nettype wire

// ----- design/first_fit_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// Heap allocator with 16-byte headers and a first-fit LIFO free list.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it clears the header store, one
// entry per cycle. A request transfers when start is high and busy is low; its
// result shows on the rsp_ ports for one cycle, marked by rsp_strobe, and must
// be taken then. A free goes from transfer through the pointer header read,
// the header check and the release to the strobe; a shrinking realloc skips
// the release. An allocate walks the free list, reading one header from the
// header store into a register and checking it the next cycle, then unlinks,
// splits and marks a fit or grows the heap top, and a growing realloc adds the
// pointer check and the release of the old block. The statistics ports follow
// the internal counters and are valid with the strobe.
`default_nettype none

module first_fit_free_list_allocator #(
   parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [16:0] req_size_bytes,
   input  wire logic [15:0] req_pointer_offset,
   input  wire logic        req_pointer_present,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic             rsp_result_present,
   output logic [15:0]      rsp_result_offset,
   output logic [16:0]      rsp_granted_bytes,
   output logic [16:0]      rsp_bytes_in_use,
   output logic [16:0]      rsp_peak_bytes,
   output logic [31:0]      rsp_alloc_total,
   output logic [31:0]      rsp_free_total
);

   ffa_pkg::cmd_type  cmd;
   ffa_pkg::stat_type stat;

   // sequencer
   ffa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // storage and arithmetic
   ffa_datapath #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_action),
      .req_size_bytes      (req_size_bytes),
      .req_pointer_offset  (req_pointer_offset),
      .req_pointer_present (req_pointer_present),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_result_present  (rsp_result_present),
      .rsp_result_offset   (rsp_result_offset),
      .rsp_granted_bytes   (rsp_granted_bytes),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .rsp_peak_bytes      (rsp_peak_bytes),
      .rsp_alloc_total     (rsp_alloc_total),
      .rsp_free_total      (rsp_free_total)
   );

endmodule

`default_nettype wire

// ----- design/ffa_checker.sv -----
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_result_present,
   input wire logic [15:0] rsp_result_offset,
   input wire logic [16:0] rsp_granted_bytes,
   input wire logic [16:0] rsp_bytes_in_use,
   input wire logic [16:0] rsp_peak_bytes
);

   // a transfer makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after a request transfer");

   // results never come in consecutive cycles
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   // a failed request returns no block
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ffa_pkg::ST_OK) |->
         (!rsp_result_present && rsp_granted_bytes == 17'd0))
      else $error("failed request reports a block");

   // no pointer means a zero offset
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_result_present) |-> (rsp_result_offset == 16'd0))
      else $error("offset set without a pointer");

   // peak never falls below current use
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_peak_bytes >= rsp_bytes_in_use))
      else $error("peak below bytes in use");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_result_present (rsp_result_present),
   .rsp_result_offset  (rsp_result_offset),
   .rsp_granted_bytes  (rsp_granted_bytes),
   .rsp_bytes_in_use   (rsp_bytes_in_use),
   .rsp_peak_bytes     (rsp_peak_bytes)
);

`default_nettype wire
